### design/blve_pkg.sv
package blve_pkg;

	localparam int MAX_DEPTH = 6;
	localparam int FRAC_BITS = 16;
	localparam int LEAF_SLOTS = 1 << MAX_DEPTH;

	localparam logic [1:0] OP_ACC  = 2'd0;
	localparam logic [1:0] OP_FIN  = 2'd1;
	localparam logic [1:0] OP_EVAL = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic [5:0]         leaf_index;
		logic signed [31:0] first_derivative;
		logic signed [31:0] second_derivative;
		logic signed [31:0] third_derivative;
		logic [31:0]        weight;
	} in_item_t;

	typedef struct packed {
		logic [5:0]         leaf_id;
		logic signed [31:0] leaf_value;
		logic signed [63:0] denominator;
		logic signed [31:0] numerator_adding;
		logic signed [31:0] numerator_multiplier;
		logic               divide_error;
		logic               last;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [1:0]         op;
		logic [5:0]         leaf;
		logic signed [31:0] g;
		logic signed [31:0] h;
		logic signed [31:0] t;
		logic [32:0]        w;
	} cmd_t;

	typedef struct packed {
		logic       newton;
		logic [6:0] leaves;
	} mode_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
		if (v > $signed({2'b00, 64'h7fffffffffffffff})) return 64'sh7fffffffffffffff;
		if (v < $signed({2'b11, 64'h8000000000000000})) return 64'sh8000000000000000;
		return v[63:0];
	endfunction

endpackage

### design/blve_front.sv
module blve_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  blve_pkg::in_item_t   item,
	input  logic                 use_weights,
	input  logic [2:0]           tree_depth,
	input  logic                 pop,
	output logic                 q_valid,
	output blve_pkg::cmd_t       q_head,
	output logic                 q_full
);
	localparam int QD = 4;

	blve_pkg::cmd_t fifo_q [QD];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic [2:0] depth;
	logic [5:0] mask;
	blve_pkg::cmd_t c;

	always_comb begin
		depth = (tree_depth > 3'(blve_pkg::MAX_DEPTH)) ? 3'(blve_pkg::MAX_DEPTH) : tree_depth;
		mask = 6'((7'd1 << depth) - 7'd1);
		c.op = item.operation;
		c.leaf = item.leaf_index & mask;
		c.g = item.first_derivative;
		c.h = item.second_derivative;
		c.t = item.third_derivative;
		c.w = use_weights ? {1'b0, item.weight} : 33'(1 << blve_pkg::FRAC_BITS);
	end

	logic push;
	assign push = take && item.operation != blve_pkg::OP_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= c;
	end

	assign q_valid = cnt_q != 3'd0;
	assign q_head = fifo_q[rp_q];
	assign q_full = cnt_q >= 3'(QD - 1);
endmodule

### design/blve_div.sv
module blve_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] n,
	input  logic [63:0] d,
	output logic        done,
	output logic [63:0] q
);
	// restoring divider, one quotient bit per cycle over n<<16 (80 bits)
	localparam int NB = 64 + blve_pkg::FRAC_BITS;
	logic [NB-1:0] num_q;
	logic [63:0] den_q;
	logic [64:0] rem_q;
	logic [NB-1:0] quo_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [64:0] sh, df;

	always_comb begin
		sh = {rem_q[63:0], num_q[NB-1]};
		df = sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= {n, {blve_pkg::FRAC_BITS{1'b0}}};
			den_q <= d;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!df[64]) begin
				rem_q <= df;
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end
	end

	assign q = (|quo_q[NB-1:64]) ? 64'hffffffffffffffff : quo_q[63:0];
endmodule

### design/blve_back.sv
module blve_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

module blve_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  blve_pkg::cmd_t       q_head,
	output logic                 pop,
	input  blve_pkg::mode_t      mode,
	input  logic [31:0]          l2_reg,
	output logic                 res_valid,
	output blve_pkg::out_item_t  res
);
	localparam logic [3:0] S_IDLE = 4'd0, S_ACC1 = 4'd1, S_ACC2 = 4'd2,
		S_EV1 = 4'd3, S_EV2 = 4'd4, S_FRA = 4'd5, S_FRD = 4'd6, S_FDIV = 4'd7,
		S_FWAIT = 4'd8;

	logic [3:0] st_q;
	blve_pkg::cmd_t c_q;
	// a slot whose valid bit is low reads as zero
	logic [blve_pkg::LEAF_SLOTS-1:0] sum_vld_q, val_vld_q;
	logic [5:0] raddr, rd_addr_q;
	logic [63:0] num_rd, den_rd;
	logic [31:0] val_rd;
	logic signed [63:0] num_cur, den_cur;
	logic signed [31:0] val_cur;
	logic sum_we, val_we;
	logic signed [63:0] num_wr, den_wr;
	logic signed [31:0] val_wr;
	logic signed [65:0] p1_q, p2_q;
	logic signed [31:0] inner_q;
	logic [6:0] k_q;
	logic fin_last;
	logic signed [63:0] nk_q, den_q;
	logic dgo, ddone;
	logic [63:0] dq, nmag, dmag;

	function automatic logic signed [65:0] fxm(input logic signed [32:0] a,
		input logic signed [32:0] b);
		logic signed [65:0] p;
		p = a * b;
		return p >>> blve_pkg::FRAC_BITS;
	endfunction

	always_comb begin
		case (st_q)
			S_IDLE: raddr = q_head.leaf;
			S_FRA, S_FRD, S_FDIV, S_FWAIT: raddr = k_q[5:0];
			default: raddr = c_q.leaf;
		endcase
	end

	assign num_cur = sum_vld_q[rd_addr_q] ? num_rd : 64'sd0;
	assign den_cur = sum_vld_q[rd_addr_q] ? den_rd : 64'sd0;
	assign val_cur = val_vld_q[rd_addr_q] ? val_rd : 32'sd0;

	assign sum_we = (st_q == S_ACC2);
	assign num_wr = blve_pkg::sat64(66'(num_cur) + p1_q);
	assign den_wr = blve_pkg::sat64(66'(den_cur) + p2_q);

	blve_ram #(.WIDTH(64), .DEPTH(blve_pkg::LEAF_SLOTS)) u_num_ram (.clk(clk),
		.we(sum_we), .waddr(c_q.leaf), .wdata(num_wr), .raddr(raddr), .rdata(num_rd));
	blve_ram #(.WIDTH(64), .DEPTH(blve_pkg::LEAF_SLOTS)) u_den_ram (.clk(clk),
		.we(sum_we), .waddr(c_q.leaf), .wdata(den_wr), .raddr(raddr), .rdata(den_rd));
	blve_ram #(.WIDTH(32), .DEPTH(blve_pkg::LEAF_SLOTS)) u_val_ram (.clk(clk),
		.we(val_we), .waddr(k_q[5:0]), .wdata(val_wr), .raddr(raddr), .rdata(val_rd));

	assign nmag = nk_q[63] ? 64'(-nk_q) : nk_q;
	assign dmag = den_q[63] ? 64'(-den_q) : den_q;

	blve_div u_div (.clk(clk), .arst_n(arst_n), .go(dgo), .n(nmag), .d(dmag),
		.done(ddone), .q(dq));

	assign pop = (st_q == S_IDLE) && q_valid;
	assign dgo = (st_q == S_FDIV);

	logic signed [63:0] den_l2;
	assign den_l2 = blve_pkg::sat64(66'(den_cur) + 66'($signed({1'b0, l2_reg})));

	logic signed [31:0] lv;
	logic neg;
	always_comb begin
		neg = (nk_q[63] == den_q[63]);
		if (nk_q == 64'sd0) lv = 32'sd0;
		else if (neg) lv = (dq >= 64'h80000000) ? 32'sh80000000 : 32'(-$signed(dq[31:0]));
		else lv = (dq >= 64'h7fffffff) ? 32'sh7fffffff : dq[31:0];
	end

	assign val_wr = (den_q == 64'sd0) ? 32'sd0 : lv;
	assign val_we = (st_q == S_FWAIT) && ddone;
	assign fin_last = (k_q + 7'd1) == mode.leaves;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			res_valid <= 1'b0;
			k_q <= '0;
			sum_vld_q <= '0;
			val_vld_q <= '0;
			rd_addr_q <= '0;
		end else begin
			res_valid <= 1'b0;
			rd_addr_q <= raddr;
			case (st_q)
				S_IDLE: if (q_valid) begin
					c_q <= q_head;
					k_q <= '0;
					case (q_head.op)
						blve_pkg::OP_ACC: st_q <= S_ACC1;
						blve_pkg::OP_FIN: st_q <= S_FRA;
						default: st_q <= S_EV1;
					endcase
				end
				S_ACC1: begin
					p1_q <= fxm($signed(c_q.w), 33'(c_q.g));
					p2_q <= mode.newton ? fxm($signed(c_q.w), 33'(c_q.h)) : 66'($signed(c_q.w));
					st_q <= S_ACC2;
				end
				S_ACC2: begin
					sum_vld_q[c_q.leaf] <= 1'b1;
					st_q <= S_IDLE;
				end
				S_EV1: begin
					if (mode.newton) begin
						p1_q <= fxm(33'(val_cur), 33'(c_q.h)) + 66'(c_q.g);
						inner_q <= blve_pkg::sat32(fxm(33'(val_cur), 33'(c_q.t))
							+ 66'(c_q.h));
					end else begin
						p1_q <= 66'(val_cur) + 66'(c_q.g);
						inner_q <= c_q.h;
					end
					st_q <= S_EV2;
				end
				S_EV2: begin
					res_valid <= 1'b1;
					res.leaf_id <= c_q.leaf;
					res.leaf_value <= '0;
					res.denominator <= '0;
					res.numerator_adding <= blve_pkg::sat32(p1_q);
					res.numerator_multiplier <= blve_pkg::sat32(fxm($signed(c_q.w),
						33'(inner_q)));
					res.divide_error <= 1'b0;
					res.last <= 1'b1;
					st_q <= S_IDLE;
				end
				S_FRA: st_q <= S_FRD;
				S_FRD: begin
					nk_q <= num_cur;
					den_q <= den_l2;
					st_q <= S_FDIV;
				end
				S_FDIV: st_q <= S_FWAIT;
				S_FWAIT: if (ddone) begin
					res_valid <= 1'b1;
					res.leaf_id <= k_q[5:0];
					res.leaf_value <= val_wr;
					res.denominator <= den_q;
					res.numerator_adding <= '0;
					res.numerator_multiplier <= '0;
					res.divide_error <= den_q == 64'sd0;
					res.last <= fin_last;
					val_vld_q[k_q[5:0]] <= 1'b1;
					if (fin_last) begin
						sum_vld_q <= '0;
						st_q <= S_IDLE;
					end else begin
						k_q <= k_q + 7'd1;
						st_q <= S_FRA;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/boosting_leaf_value_estimator.sv
// Leaf value estimator for one oblivious tree, Q16.16.
// Input: raise start with item; the item is taken at an edge where busy is low.
// Items pass a 4-entry queue (at most three held) to a back end that runs them
// one at a time; busy is high while three items wait.
// Accumulate: states ACC1 and ACC2 update the leaf sums, no result.
// Evaluate: states EV1 and EV2; its result is registered in EV2.
// Finish: 2^tree_depth results (depth capped at 6), one per leaf, each made in
// states FRA, FRD, FDIV and FWAIT with the 80-step bit-serial divider;
// last marks the final leaf.
// Results appear on res for one cycle with res_valid; they cannot be stalled.
// Configuration by APB writes at 4*index, 32-bit data; the user must write only
// while idle, as the block does not enforce it.
// Reset clears all sums and stored leaf values; config registers take defaults.
module boosting_leaf_value_estimator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  blve_pkg::in_item_t   item,
	output logic                 res_valid,
	output blve_pkg::out_item_t  res,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	localparam logic [1:0] R_NEWTON = 2'd0, R_WEIGHTS = 2'd1, R_L2 = 2'd2, R_DEPTH = 2'd3;

	logic newton_q, weights_q;
	logic [31:0] l2_q;
	logic [2:0] depth_q;
	logic q_valid, q_full, pop;
	blve_pkg::cmd_t q_head;
	blve_pkg::mode_t mode;
	logic [2:0] dc;

	assign pready = 1'b1;
	assign busy = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newton_q <= 1'b0;
			weights_q <= 1'b0;
			l2_q <= 32'd196608;
			depth_q <= 3'd6;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (paddr[3:2])
				R_NEWTON: newton_q <= pwdata[0];
				R_WEIGHTS: weights_q <= pwdata[0];
				R_L2: l2_q <= pwdata;
				R_DEPTH: depth_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			R_NEWTON: prdata = {31'd0, newton_q};
			R_WEIGHTS: prdata = {31'd0, weights_q};
			R_L2: prdata = l2_q;
			R_DEPTH: prdata = {29'd0, depth_q};
			default: prdata = '0;
		endcase
		dc = (depth_q > 3'(blve_pkg::MAX_DEPTH)) ? 3'(blve_pkg::MAX_DEPTH) : depth_q;
		mode.newton = newton_q;
		mode.leaves = 7'd1 << dc;
	end

	blve_front u_front (.clk(clk), .arst_n(arst_n), .take(start && !busy), .item(item),
		.use_weights(weights_q), .tree_depth(depth_q), .pop(pop), .q_valid(q_valid),
		.q_head(q_head), .q_full(q_full));

	blve_back u_back (.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head),
		.pop(pop), .mode(mode), .l2_reg(l2_q), .res_valid(res_valid), .res(res));
endmodule
